// ===== rtl/core/tsp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the topological sort / path count block.
// Holds widths, opcode names and the records shared by front, back and top.
package tsp_pkg;

  localparam int MAX_STATES = 1024;
  localparam int MAX_ARCS   = 4096;
  localparam int ST_W       = 10;   // state number
  localparam int AIX_W      = 12;   // arc index
  localparam int ACNT_W     = 13;   // arc count, holds MAX_ARCS
  localparam int DEG_W      = 13;
  localparam int PATH_W     = 63;
  localparam int NUM_W      = 11;   // state count, holds MAX_STATES
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;

  localparam logic [PATH_W-1:0] PATH_MAX = {PATH_W{1'b1}};

  typedef logic [1:0] op_t;
  localparam op_t OP_LOAD  = 2'd0;
  localparam op_t OP_LAST  = 2'd1;
  localparam op_t OP_QUERY = 2'd2;

  // classified request handed from front to back
  typedef struct packed {
    op_t             op;
    logic [ST_W-1:0] src;
    logic [ST_W-1:0] dst;
    logic            has_dst;
    logic            fin;
    logic [ST_W-1:0] q;
  } item_t;

  // back status seen by the front
  typedef struct packed {
    logic clearing;
  } status_t;

endpackage

// ===== rtl/core/tsp_if.sv =====
`timescale 1ns / 1ps
// Request and result channel interfaces of the sort block.
// Stand-alone; widths are fixed by the field definitions.
interface tsp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [9:0] src_state;
  logic [9:0] dst_state;
  logic       has_dst;
  logic       src_final;
  logic       last_arc;
  logic [9:0] query_state;

  modport source (output valid, cmd, src_state, dst_state, has_dst, src_final,
                  last_arc, query_state, input ready);
  modport sink (input valid, cmd, src_state, dst_state, has_dst, src_final,
                last_arc, query_state, output ready);
endinterface

interface tsp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        loop_free;
  logic        count_overflow;
  logic [62:0] path_count;
  logic [10:0] states_seen;
  logic [9:0]  new_number;

  modport source (output valid, kind, loop_free, count_overflow, path_count,
                  states_seen, new_number, input ready);
  modport sink (input valid, kind, loop_free, count_overflow, path_count,
                states_seen, new_number, output ready);
endinterface

// ===== rtl/core/tsp_front.sv =====
`timescale 1ns / 1ps
// Front part: takes requests, classifies them and queues them for the back.
// Depends on tsp_pkg and tsp_in_if.
module tsp_front import tsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tsp_in_if.sink     in_ch,
  input  status_t    status,
  input  logic       pop,
  output logic       item_valid,
  output item_t      item
);

  item_t             fifo [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              do_pop;
  item_t             cls;

  assign in_ch.ready = (count != QDEPTH[QPTR_W:0]) && !status.clearing;
  assign push        = in_ch.valid && in_ch.ready;
  assign item_valid  = (count != '0);
  assign do_pop      = pop && item_valid;
  assign item        = fifo[rd_ptr];

  // classify the request
  always_comb begin
    cls.src     = in_ch.src_state;
    cls.dst     = in_ch.dst_state;
    cls.has_dst = in_ch.has_dst;
    cls.fin     = in_ch.src_final;
    cls.q       = in_ch.query_state;
    if (in_ch.cmd) begin
      cls.op = OP_QUERY;
    end else if (in_ch.last_arc) begin
      cls.op = OP_LAST;
    end else begin
      cls.op = OP_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/tsp_back.sv =====
`timescale 1ns / 1ps
// Back part: arc store, state tables and the sequencer for load, sort, query.
// Depends on tsp_pkg and tsp_out_if.
module tsp_back import tsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  item_t      item,
  output logic       pop,
  output status_t    status,
  tsp_out_if.source  out_ch
);

  typedef struct packed {
    logic [ST_W-1:0] src;
    logic [ST_W-1:0] tgt;
    logic            tv;
  } arc_rec_t;

  typedef struct packed {
    logic             fin;
    logic             seen;
    logic [AIX_W-1:0] idx;
  } st_rec_t;

  typedef struct packed {
    logic            done;
    logic [ST_W-1:0] num;
  } trt_rec_t;

  localparam logic [4:0] S_CLR0 = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_DEC  = 5'd2;
  localparam logic [4:0] S_LD2  = 5'd3;
  localparam logic [4:0] S_Q2   = 5'd4;
  localparam logic [4:0] S_CLR1 = 5'd5;
  localparam logic [4:0] S_INIT = 5'd6;
  localparam logic [4:0] S_POP  = 5'd7;
  localparam logic [4:0] S_CUR  = 5'd8;
  localparam logic [4:0] S_CUR2 = 5'd9;
  localparam logic [4:0] S_ARC  = 5'd10;
  localparam logic [4:0] S_ARC2 = 5'd11;
  localparam logic [4:0] S_ARC3 = 5'd12;
  localparam logic [4:0] S_END  = 5'd13;
  localparam logic [4:0] S_SUM  = 5'd14;
  localparam logic [4:0] S_SUM2 = 5'd15;
  localparam logic [4:0] S_RES  = 5'd16;
  localparam logic [4:0] S_CLR2 = 5'd17;

  localparam logic [ST_W-1:0] ST_LAST = {ST_W{1'b1}};

  // memories
  arc_rec_t          arc_mem  [MAX_ARCS];
  st_rec_t           st_mem   [MAX_STATES];
  logic [DEG_W-1:0]  deg_mem  [MAX_STATES];
  trt_rec_t          trt_mem  [MAX_STATES];
  logic [PATH_W-1:0] path_mem [MAX_STATES];
  logic [ST_W-1:0]   stk_mem  [MAX_STATES];

  // memory ports
  logic arc_we; logic [AIX_W-1:0] arc_waddr, arc_raddr; arc_rec_t arc_wdata, arc_q;
  logic st_we;  logic [ST_W-1:0] st_waddr, st_raddr;   st_rec_t st_wdata, st_q;
  logic deg_we; logic [ST_W-1:0] deg_waddr, deg_raddr;
  logic [DEG_W-1:0] deg_wdata, deg_q;
  logic trt_we; logic [ST_W-1:0] trt_waddr, trt_raddr; trt_rec_t trt_wdata, trt_q;
  logic path_we; logic [ST_W-1:0] path_waddr, path_raddr;
  logic [PATH_W-1:0] path_wdata, path_q;
  logic stk_we; logic [ST_W-1:0] stk_waddr, stk_raddr; logic [ST_W-1:0] stk_wdata, stk_q;

  // sequencer registers
  logic [4:0]        state, state_next;
  item_t             cur_item;
  logic [NUM_W-1:0]  cnt;
  logic [NUM_W-1:0]  sp;
  logic [NUM_W-1:0]  n;
  logic [ACNT_W-1:0] a;
  logic [ACNT_W-1:0] arcs_loaded;
  logic [ST_W-1:0]   cur;
  logic [ST_W-1:0]   t;
  logic [PATH_W-1:0] pc;
  logic [PATH_W-1:0] total;
  logic              ovf;
  logic              cyc;
  logic              lf;
  logic              self_loop;
  logic [NUM_W-1:0]  states;

  logic out_free;
  logic [PATH_W:0] walk_sum, acc_sum;
  logic [DEG_W-1:0] deg_dec;
  logic [NUM_W-1:0] src_p1, dst_p1, states_ld;

  assign out_free  = !out_ch.valid || out_ch.ready;
  assign walk_sum  = {1'b0, path_q} + {1'b0, pc};
  assign acc_sum   = {1'b0, total} + {1'b0, path_q};
  assign deg_dec   = deg_q - 1'b1;
  assign src_p1    = {1'b0, cur_item.src} + 1'b1;
  assign dst_p1    = {1'b0, cur_item.dst} + 1'b1;
  assign pop       = (state == S_IDLE) && item_valid;
  assign status.clearing = (state == S_CLR0);

  // highest state number plus one over stored arcs
  always_comb begin
    states_ld = states;
    if (src_p1 > states_ld) states_ld = src_p1;
    if (cur_item.has_dst && dst_p1 > states_ld) states_ld = dst_p1;
  end

  // memory blocks, registered read
  always_ff @(posedge clk) begin
    if (arc_we) arc_mem[arc_waddr] <= arc_wdata;
    arc_q <= arc_mem[arc_raddr];
  end
  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    st_q <= st_mem[st_raddr];
  end
  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
    deg_q <= deg_mem[deg_raddr];
  end
  always_ff @(posedge clk) begin
    if (trt_we) trt_mem[trt_waddr] <= trt_wdata;
    trt_q <= trt_mem[trt_raddr];
  end
  always_ff @(posedge clk) begin
    if (path_we) path_mem[path_waddr] <= path_wdata;
    path_q <= path_mem[path_raddr];
  end
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_q <= stk_mem[stk_raddr];
  end

  // memory addressing and writes
  always_comb begin
    arc_we = 1'b0; arc_waddr = arcs_loaded[AIX_W-1:0]; arc_raddr = a[AIX_W-1:0];
    arc_wdata.src = cur_item.src;
    arc_wdata.tgt = cur_item.has_dst ? cur_item.dst : '0;
    arc_wdata.tv  = cur_item.has_dst;
    st_we = 1'b0; st_waddr = cnt[ST_W-1:0]; st_wdata = '0; st_raddr = cnt[ST_W-1:0];
    deg_we = 1'b0; deg_waddr = cnt[ST_W-1:0]; deg_wdata = '0; deg_raddr = cur_item.dst;
    trt_we = 1'b0; trt_waddr = cnt[ST_W-1:0]; trt_wdata = '0; trt_raddr = cur_item.q;
    path_we = 1'b0; path_waddr = cnt[ST_W-1:0]; path_wdata = '0;
    path_raddr = cnt[ST_W-1:0];
    stk_we = 1'b0; stk_waddr = sp[ST_W-1:0]; stk_wdata = '0;
    stk_raddr = sp[ST_W-1:0] - 1'b1;
    case (state)
      S_CLR0: begin
        st_we = 1'b1; deg_we = 1'b1; trt_we = 1'b1; path_we = 1'b1;
      end
      S_DEC: begin
        st_raddr = cur_item.src;
      end
      S_LD2: begin
        arc_we        = 1'b1;
        st_we         = 1'b1;
        st_waddr      = cur_item.src;
        st_wdata.fin  = st_q.fin | cur_item.fin;
        st_wdata.seen = 1'b1;
        st_wdata.idx  = st_q.seen ? st_q.idx : arcs_loaded[AIX_W-1:0];
        deg_we        = cur_item.has_dst;
        deg_waddr     = cur_item.dst;
        deg_wdata     = deg_q + 1'b1;
      end
      S_CLR1: begin
        trt_we = 1'b1; path_we = 1'b1;
      end
      S_INIT: begin
        path_we    = 1'b1;
        path_waddr = '0;
        path_wdata = {{(PATH_W-1){1'b0}}, 1'b1};
        stk_we     = 1'b1;
        stk_waddr  = '0;
      end
      S_CUR: begin
        trt_we         = 1'b1;
        trt_waddr      = stk_q;
        trt_wdata.done = 1'b1;
        trt_wdata.num  = n[ST_W-1:0];
        st_raddr       = stk_q;
        path_raddr     = stk_q;
      end
      S_ARC2: begin
        deg_raddr  = arc_q.tgt;
        path_raddr = arc_q.tgt;
        trt_raddr  = arc_q.tgt;
      end
      S_ARC3: begin
        deg_we     = 1'b1;
        deg_waddr  = t;
        deg_wdata  = deg_dec;
        path_we    = !ovf;
        path_waddr = t;
        path_wdata = walk_sum[PATH_W] ? PATH_MAX : walk_sum[PATH_W-1:0];
        stk_we     = !trt_q.done && (deg_dec == '0) && !sp[ST_W];
        stk_wdata  = t;
      end
      S_CLR2: begin
        st_we = 1'b1; deg_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_CLR0: if (cnt[ST_W-1:0] == ST_LAST) state_next = S_IDLE;
      S_IDLE: if (item_valid) state_next = S_DEC;
      S_DEC: begin
        if (cur_item.op == OP_QUERY) begin
          state_next = S_Q2;
        end else if (arcs_loaded < ACNT_W'(MAX_ARCS)) begin
          state_next = S_LD2;
        end else if (cur_item.op == OP_LAST) begin
          state_next = S_CLR1;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_LD2: state_next = (cur_item.op == OP_LAST) ? S_CLR1 : S_IDLE;
      S_Q2: if (out_free) state_next = S_IDLE;
      S_CLR1: begin
        if (cnt[ST_W-1:0] == ST_LAST) state_next = S_INIT;
      end
      S_INIT: state_next = (!self_loop && states != '0) ? S_POP : S_RES;
      S_POP: state_next = (sp == '0) ? S_END : S_CUR;
      S_CUR: state_next = S_CUR2;
      S_CUR2: state_next = st_q.seen ? S_ARC : S_POP;
      S_ARC: state_next = (a >= arcs_loaded) ? S_POP : S_ARC2;
      S_ARC2: begin
        if (arc_q.src != cur) begin
          state_next = S_POP;
        end else if (!arc_q.tv) begin
          state_next = S_ARC;
        end else begin
          state_next = S_ARC3;
        end
      end
      S_ARC3: state_next = trt_q.done ? S_END : S_ARC;
      S_END: state_next = (!cyc && n == states) ? S_SUM : S_RES;
      S_SUM: state_next = (cnt == states) ? S_RES : S_SUM2;
      S_SUM2: state_next = S_SUM;
      S_RES: if (out_free) state_next = S_CLR2;
      S_CLR2: if (cnt[ST_W-1:0] == ST_LAST) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sweep and sum counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == S_CLR0 || state == S_CLR1 || state == S_CLR2 ||
                 state == S_SUM2) begin
      cnt <= cnt + 1'b1;
    end else if (state == S_END || state == S_LD2 || (state == S_RES && out_free) ||
                 (state == S_DEC && cur_item.op == OP_LAST &&
                  arcs_loaded >= ACNT_W'(MAX_ARCS))) begin
      cnt <= '0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) cur_item <= item;
    case (state)
      S_INIT: begin
        n     <= '0;
        sp    <= {{(NUM_W-1){1'b0}}, 1'b1};
        ovf   <= 1'b0;
        cyc   <= 1'b0;
        total <= '0;
        lf    <= 1'b0;
      end
      S_POP: if (sp != '0) sp <= sp - 1'b1;
      S_CUR: begin
        cur <= stk_q;
        n   <= n + 1'b1;
      end
      S_CUR2: begin
        pc <= path_q;
        a  <= {1'b0, st_q.idx};
      end
      S_ARC2: begin
        t <= arc_q.tgt;
        if (!arc_q.tv) a <= a + 1'b1;
      end
      S_ARC3: begin
        if (!ovf && walk_sum[PATH_W]) ovf <= 1'b1;
        if (trt_q.done) begin
          cyc <= 1'b1;
        end else begin
          a <= a + 1'b1;
          if (deg_dec == '0 && !sp[ST_W]) sp <= sp + 1'b1;
        end
      end
      S_END: begin
        lf  <= !cyc && (n == states);
      end
      default: begin
      end
    endcase
    if (state == S_SUM2 && st_q.fin && !ovf) begin
      if (acc_sum[PATH_W]) begin
        ovf   <= 1'b1;
        total <= PATH_MAX;
      end else begin
        total <= acc_sum[PATH_W-1:0];
      end
    end
  end

  // load bookkeeping and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR0;
      arcs_loaded <= '0;
      self_loop   <= 1'b0;
      states      <= '0;
    end else begin
      state <= state_next;
      if (state == S_LD2) begin
        arcs_loaded <= arcs_loaded + 1'b1;
        states      <= states_ld;
        if (cur_item.has_dst && cur_item.src == cur_item.dst) self_loop <= 1'b1;
      end
      if (state == S_CLR2 && cnt[ST_W-1:0] == ST_LAST) begin
        arcs_loaded <= '0;
        self_loop   <= 1'b0;
        states      <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == S_Q2 && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (state == S_RES && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_Q2 && out_free) begin
      out_ch.kind           <= 1'b1;
      out_ch.loop_free      <= 1'b0;
      out_ch.count_overflow <= 1'b0;
      out_ch.path_count     <= '0;
      out_ch.states_seen    <= '0;
      out_ch.new_number     <= trt_q.done ? trt_q.num : '0;
    end else if (state == S_RES && out_free) begin
      out_ch.kind           <= 1'b0;
      out_ch.loop_free      <= lf;
      out_ch.count_overflow <= lf && ovf;
      out_ch.path_count     <= lf ? (ovf ? PATH_MAX : total) : '0;
      out_ch.states_seen    <= states;
      out_ch.new_number     <= '0;
    end
  end

endmodule

// ===== rtl/core/dag_topsort_path_count.sv =====
`timescale 1ns / 1ps
// Topological sort with path count. In the back sequencer a load or query goes
// through the decode state, then its load or query state; a query answer is
// registered once the output is free. A last arc starts a sort: a clearing
// sweep, the walk, the final-state sum if loop-free, the result, and a second
// clearing sweep, both sweeps 1024-entry. After rst a 1024-entry clearing pass
// runs and no request is taken. Depends on tsp_pkg, tsp_if, tsp_front, tsp_back.
module dag_topsort_path_count import tsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tsp_in_if.sink     in_ch,
  tsp_out_if.source  out_ch
);

  status_t status;
  logic    pop;
  logic    item_valid;
  item_t   item;

  tsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .status     (status),
    .pop        (pop),
    .item_valid (item_valid),
    .item       (item)
  );

  tsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .pop        (pop),
    .status     (status),
    .out_ch     (out_ch)
  );

endmodule
